FILE: design/rsqp_pkg.sv
`default_nettype none

package rsqp_pkg;

  // Table and field sizes
  localparam int MAX_CENTROIDS    = 256;
  localparam int VALUE_BITS       = 16;
  localparam int SLOT_W           = 8;
  localparam int CODE_W           = 8;
  localparam int NIBBLE_W         = 4;
  localparam int NIBBLE_CENTROIDS = 16;
  localparam int ACC_W            = 48;

  // Saturation limits of the correction accumulator
  localparam logic [ACC_W-1:0] ACC_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [ACC_W-1:0] ACC_MIN = 48'h8000_0000_0000;

  // Item operation codes
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_ENCODE = 1'b1
  } op_e;

  // One classified item as held in the queue
  typedef struct packed {
    logic                          is_encode;
    logic [SLOT_W-1:0]             slot;
    logic signed [VALUE_BITS-1:0]  x;
    logic signed [VALUE_BITS-1:0]  y;
    logic                          last;
  } item_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_out_t;

endpackage

`default_nettype wire

FILE: design/rsqp_if.sv
`default_nettype none

// Input item channel
interface rsqp_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   operation;
  logic [7:0]                             centroid_index;
  logic signed [rsqp_pkg::VALUE_BITS-1:0] target_value;
  logic signed [rsqp_pkg::VALUE_BITS-1:0] primary_recon;
  logic                                   last_dim;

  modport source (output valid, operation, centroid_index, target_value, primary_recon,
                  last_dim, input ready);
  modport sink (input valid, operation, centroid_index, target_value, primary_recon,
                last_dim, output ready);
endinterface

// Result channel
interface rsqp_out_if;
  logic                              valid;
  logic                              ready;
  logic [7:0]                        code_byte;
  logic signed [rsqp_pkg::ACC_W-1:0] correction;
  logic                              vector_end;
  logic                              saturated;

  modport source (output valid, code_byte, correction, vector_end, saturated,
                  input ready);
  modport sink (input valid, code_byte, correction, vector_end, saturated,
                output ready);
endinterface

// Configuration write channel
interface rsqp_cfg_if;
  logic valid;
  logic ready;
  logic code_width_8;

  modport source (output valid, code_width_8, input ready);
  modport sink (input valid, code_width_8, output ready);
endinterface

`default_nettype wire

FILE: design/rsqp_front.sv
`default_nettype none

// Accepts items, drops out-of-range loads and queues the rest (two entries)
module rsqp_front #(
  parameter int MAX_CENTROIDS = rsqp_pkg::MAX_CENTROIDS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  rsqp_in_if.sink               in_ch,
  output rsqp_pkg::q_out_t      q_o,
  input  wire logic             q_pop_i
);

  localparam logic [rsqp_pkg::SLOT_W:0] SLOT_LIMIT = (rsqp_pkg::SLOT_W+1)'(MAX_CENTROIDS);

  rsqp_pkg::item_t q_mem [2];
  logic [1:0]      count_q, count_d;
  logic            wr_ptr_q, rd_ptr_q;
  logic            is_encode, keep, push;
  rsqp_pkg::item_t new_item;

  // Classification
  assign is_encode = (in_ch.operation == rsqp_pkg::OP_ENCODE);
  assign keep      = is_encode || ({1'b0, in_ch.centroid_index} < SLOT_LIMIT);

  assign new_item.is_encode = is_encode;
  assign new_item.slot      = in_ch.centroid_index;
  assign new_item.x         = in_ch.target_value;
  assign new_item.y         = in_ch.primary_recon;
  assign new_item.last      = in_ch.last_dim;

  assign in_ch.ready = (count_q != 2'd2);
  assign push        = in_ch.valid && in_ch.ready && keep;

  // Queue occupancy
  always_comb begin
    count_d = count_q;
    if (push && !q_pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && q_pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= new_item;
    end
  end

  assign q_o.valid = (count_q != 2'd0);
  assign q_o.item  = q_mem[rd_ptr_q];

endmodule

`default_nettype wire

FILE: design/rsqp_back.sv
`default_nettype none

// Centroid table, binary search, dot-product accumulation and code packing
module rsqp_back #(
  parameter int MAX_CENTROIDS = rsqp_pkg::MAX_CENTROIDS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  rsqp_cfg_if.sink              cfg_ch,
  input  rsqp_pkg::q_out_t      q_i,
  output logic                  q_pop_o,
  rsqp_out_if.source            out_ch
);

  localparam int IDX_W = $clog2(MAX_CENTROIDS);
  localparam int VB    = rsqp_pkg::VALUE_BITS;
  localparam int AW    = rsqp_pkg::ACC_W;
  localparam int PW    = 2 * VB;
  localparam int NW    = rsqp_pkg::NIBBLE_W;
  localparam int CW    = rsqp_pkg::CODE_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_MUL    = 5'b00100,
    S_ACC    = 5'b01000,
    S_FIN    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration register
  logic code_width_8_q;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_width_8_q <= 1'b0;
    end else if (cfg_ch.valid) begin
      code_width_8_q <= cfg_ch.code_width_8;
    end
  end

  // Search bounds
  logic [IDX_W-1:0] hmax, mid0;
  assign hmax = code_width_8_q ? IDX_W'(MAX_CENTROIDS - 1)
                               : IDX_W'(rsqp_pkg::NIBBLE_CENTROIDS - 1);
  assign mid0 = hmax >> 1;

  // Centroid table: one write port, two registered read ports
  logic signed [VB-1:0] cent_mem [MAX_CENTROIDS];
  logic signed [VB-1:0] rd_a_q, rd_b_q;
  logic                 mem_we, rd_pair;
  logic [IDX_W-1:0]     rd_addr_a, rd_addr_b;

  assign rd_addr_b = rd_pair ? rd_addr_a + 1'b1 : rd_addr_a;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cent_mem[q_i.item.slot[IDX_W-1:0]] <= q_i.item.x;
    end
    rd_a_q <= cent_mem[rd_addr_a];
    rd_b_q <= cent_mem[rd_addr_b];
  end

  // Item and search registers
  logic signed [VB:0]   r_q;
  logic signed [VB-1:0] y_q;
  logic                 last_q, item_ld;
  logic [IDX_W-1:0]     lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, k_q, k_d;
  logic signed [PW-1:0] prod_q;
  logic [CW-1:0]        byte_q;

  // Midpoint test: go left when 2r < c[mid] + c[mid+1]
  logic signed [VB+1:0] two_r, c_sum;
  logic                 go_left;
  logic [IDX_W-1:0]     lo_n, hi_n, mid_n;
  logic [IDX_W:0]       lh_sum;

  assign two_r   = {r_q, 1'b0};
  assign c_sum   = {{2{rd_a_q[VB-1]}}, rd_a_q} + {{2{rd_b_q[VB-1]}}, rd_b_q};
  assign go_left = (two_r < c_sum);
  assign lo_n    = go_left ? lo_q : mid_q + 1'b1;
  assign hi_n    = go_left ? mid_q : hi_q;
  assign lh_sum  = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_n   = lh_sum[IDX_W:1];

  // Saturating accumulate
  logic [AW-1:0] acc_q, acc_d, acc_n;
  logic          clip_q, clip_d;
  logic [AW:0]   sum_w;
  logic          acc_ovf;

  assign sum_w   = {acc_q[AW-1], acc_q} + {{(AW+1-PW){prod_q[PW-1]}}, prod_q};
  assign acc_ovf = (sum_w[AW] != sum_w[AW-1]);
  assign acc_n   = acc_ovf ? (sum_w[AW] ? rsqp_pkg::ACC_MIN : rsqp_pkg::ACC_MAX)
                           : sum_w[AW-1:0];

  // Doubling for the final correction
  logic          dbl_ovf;
  logic [AW-1:0] cor_val;

  assign dbl_ovf = (acc_q[AW-1] != acc_q[AW-2]);
  assign cor_val = dbl_ovf ? (acc_q[AW-1] ? rsqp_pkg::ACC_MIN : rsqp_pkg::ACC_MAX)
                           : {acc_q[AW-2:0], 1'b0};

  // Code packing
  logic          odd_q, odd_d, odd_n;
  logic [NW-1:0] pend_q, pend_d, pend_n;
  logic [CW-1:0] pack_byte;
  logic          emit;

  always_comb begin
    if (code_width_8_q) begin
      pack_byte = CW'(k_q);
      emit      = 1'b1;
      odd_n     = 1'b0;
      pend_n    = '0;
    end else if (odd_q) begin
      pack_byte = {k_q[NW-1:0], pend_q};
      emit      = 1'b1;
      odd_n     = 1'b0;
      pend_n    = '0;
    end else begin
      pack_byte = {{(CW-NW){1'b0}}, k_q[NW-1:0]};
      emit      = last_q;
      odd_n     = 1'b1;
      pend_n    = k_q[NW-1:0];
    end
  end

  // Output register
  logic          out_valid_q, out_load, can_load;
  logic [CW-1:0] out_byte_q, out_byte_d;
  logic [AW-1:0] out_cor_q, out_cor_d;
  logic          out_end_q, out_end_d, out_sat_q, out_sat_d;

  assign can_load = !out_valid_q || out_ch.ready;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    k_d        = k_q;
    acc_d      = acc_q;
    clip_d     = clip_q;
    odd_d      = odd_q;
    pend_d     = pend_q;
    q_pop_o    = 1'b0;
    mem_we     = 1'b0;
    item_ld    = 1'b0;
    rd_addr_a  = '0;
    rd_pair    = 1'b0;
    out_load   = 1'b0;
    out_byte_d = pack_byte;
    out_cor_d  = '0;
    out_end_d  = 1'b0;
    out_sat_d  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_i.valid) begin
          q_pop_o = 1'b1;
          if (!q_i.item.is_encode) begin
            mem_we = 1'b1;
          end else begin
            item_ld   = 1'b1;
            lo_d      = '0;
            hi_d      = hmax;
            mid_d     = mid0;
            rd_addr_a = mid0;
            rd_pair   = 1'b1;
            state_d   = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (lo_n < hi_n) begin
          lo_d      = lo_n;
          hi_d      = hi_n;
          mid_d     = mid_n;
          rd_addr_a = mid_n;
          rd_pair   = 1'b1;
        end else begin
          k_d       = lo_n;
          rd_addr_a = lo_n;
          state_d   = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        if (last_q) begin
          acc_d   = acc_n;
          clip_d  = clip_q | acc_ovf;
          odd_d   = odd_n;
          pend_d  = pend_n;
          state_d = S_FIN;
        end else if (!emit || can_load) begin
          acc_d    = acc_n;
          clip_d   = clip_q | acc_ovf;
          odd_d    = odd_n;
          pend_d   = pend_n;
          out_load = emit;
          state_d  = S_IDLE;
        end
      end
      S_FIN: begin
        out_byte_d = byte_q;
        out_cor_d  = cor_val;
        out_end_d  = 1'b1;
        out_sat_d  = clip_q | dbl_ovf;
        if (can_load) begin
          out_load = 1'b1;
          acc_d    = '0;
          clip_d   = 1'b0;
          odd_d    = 1'b0;
          pend_d   = '0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      clip_q      <= 1'b0;
      odd_q       <= 1'b0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      clip_q  <= clip_d;
      odd_q   <= odd_d;
      pend_q  <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    k_q   <= k_d;
    if (item_ld) begin
      r_q    <= {q_i.item.x[VB-1], q_i.item.x} - {q_i.item.y[VB-1], q_i.item.y};
      y_q    <= q_i.item.y;
      last_q <= q_i.item.last;
    end
    if (state_q == S_MUL) begin
      prod_q <= y_q * rd_a_q;
    end
    if (state_q == S_ACC) begin
      byte_q <= pack_byte;
    end
    if (out_load) begin
      out_byte_q <= out_byte_d;
      out_cor_q  <= out_cor_d;
      out_end_q  <= out_end_d;
      out_sat_q  <= out_sat_d;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.code_byte  = out_byte_q;
  assign out_ch.correction = out_cor_q;
  assign out_ch.vector_end = out_end_q;
  assign out_ch.saturated  = out_sat_q;

`ifndef SYNTH
  // Search interval is never empty while searching
  a_search_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (lo_q < hi_q))
    else $error("search interval collapsed");

  // Upper bound stays inside the active table
  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (hi_q <= hmax))
    else $error("search bound beyond table");

  // Mid-vector results carry no correction
  a_mid_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_end_q) |-> (out_cor_q == '0 && !out_sat_q))
    else $error("correction on a non-final byte");

  // Vector state is cleared once the final byte is handed over
  a_vector_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && can_load) |=> (acc_q == '0 && !clip_q && !odd_q))
    else $error("vector state not cleared");

  // Byte mode leaves no half-filled byte behind
  a_byte_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC && code_width_8_q && state_d != S_ACC) |=> !odd_q)
    else $error("pending nibble in byte mode");
`endif

endmodule

`default_nettype wire

FILE: design/residual_scalar_quantize_pack_unit.sv
`default_nettype none

// An encode item passes from the queue through the back end states IDLE, SEARCH, MUL and
// ACC into the output register, with FIN added on the last dimension. SEARCH runs S steps,
// 4 for 16 centroids, up to ceil(log2(MAX_CENTROIDS)) otherwise, each step one dual-read
// table access. The back end takes no new item until an encode is back in IDLE; loads are
// written to the table from IDLE and run one per cycle while the back end is idle.
// Reset clears control state and code_width_8; centroid table is undefined until loaded.
module residual_scalar_quantize_pack_unit #(
  parameter int MAX_CENTROIDS = rsqp_pkg::MAX_CENTROIDS
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  rsqp_in_if.sink       in_ch_i,
  rsqp_cfg_if.sink      cfg_ch_i,
  rsqp_out_if.source    out_ch_o
);

  rsqp_pkg::q_out_t q;
  logic             q_pop;

  // Front end: transfer, classification and queue
  rsqp_front #(
    .MAX_CENTROIDS(MAX_CENTROIDS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch_i),
    .q_o    (q),
    .q_pop_i(q_pop)
  );

  // Back end: table, search, accumulation and packing
  rsqp_back #(
    .MAX_CENTROIDS(MAX_CENTROIDS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_ch (cfg_ch_i),
    .q_i    (q),
    .q_pop_o(q_pop),
    .out_ch (out_ch_o)
  );

endmodule

`default_nettype wire
